// ===== sv/hsl_pkg.sv =====
// ----------------------------------------------------------------------------
// hsl_pkg: shared types and constants for the RGB to HSL converter
// Channel widths, result widths and the side data that rides the divide chain.
// ----------------------------------------------------------------------------
package hsl_pkg;

    localparam int CHAN_W  = 8;   // one color channel
    localparam int HUE_W   = 9;   // hue in degrees, 0..359
    localparam int LIGHT_W = 9;   // hi + lo, 0..510
    localparam int M_W     = 12;  // sextant position scaled by d, below 6*255
    localparam int N_W     = 17;  // 60 * M, below 360*255

    // Payload that travels alongside the two dividers
    typedef struct packed {
        logic               gray;       // all channels equal: hue and saturation are zero
        logic [LIGHT_W-1:0] lightness;
        logic [CHAN_W-1:0]  opacity;
    } hsl_side_t;

endpackage

// ===== sv/rgb_to_hsl_convert_unit.sv =====
// ----------------------------------------------------------------------------
// rgb_to_hsl_convert_unit: RGB pixel to hue, saturation and lightness
// Preparation stage followed by two parallel chains of division cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_valid/s_ready) carries one 8-bit RGB pixel plus opacity.
//   Result channel (m_valid/m_ready) carries hue in degrees, saturation
//   scaled to 2^SATURATION_BITS-1, lightness as hi+lo (of 510) and the
//   opacity copied through.
//   The pipeline is one preparation stage, then one cell per quotient bit,
//   DIV_BITS = max(SATURATION_BITS, 9), in each divider. Throughput is one
//   pixel per cycle while the receiver accepts results; each cell of the two
//   divide chains holds a different pixel.
//   When the receiver stalls with a result pending, the whole chain holds
//   and s_ready drops in the same cycle; it rises again as soon as the
//   result transfers, so no pixel is lost or repeated.
//   Reset clears all stage valid bits; results in flight are dropped.
//   A gray pixel (all channels equal) gives hue and saturation of zero.
// ----------------------------------------------------------------------------
module rgb_to_hsl_convert_unit import hsl_pkg::*; #(
    parameter int SATURATION_BITS = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [CHAN_W-1:0]          s_red,
    input  logic [CHAN_W-1:0]          s_green,
    input  logic [CHAN_W-1:0]          s_blue,
    input  logic [CHAN_W-1:0]          s_opacity_in,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [HUE_W-1:0]           m_hue,
    output logic [SATURATION_BITS-1:0] m_saturation,
    output logic [LIGHT_W-1:0]         m_lightness,
    output logic [CHAN_W-1:0]          m_opacity_out
);

    localparam int DIV_BITS = (SATURATION_BITS > HUE_W) ? SATURATION_BITS : HUE_W;

    logic advance;

    logic [CHAN_W-1:0]   hue_rem [0:DIV_BITS];
    logic [CHAN_W-1:0]   hue_den [0:DIV_BITS];
    logic [DIV_BITS-1:0] hue_low [0:DIV_BITS];
    logic [DIV_BITS-1:0] hue_quo [0:DIV_BITS];
    logic [CHAN_W-1:0]   sat_rem [0:DIV_BITS];
    logic [CHAN_W-1:0]   sat_den [0:DIV_BITS];
    logic [DIV_BITS-1:0] sat_low [0:DIV_BITS];
    logic [DIV_BITS-1:0] sat_quo [0:DIV_BITS];
    hsl_side_t           side    [0:DIV_BITS];

    hsl_side_t             side_reg  [1:DIV_BITS];
    logic [DIV_BITS:0]     valid_reg;
    logic [DIV_BITS:0]     valid_next;

    // Whole chain moves when the output slot is free or being taken
    assign advance = !valid_reg[DIV_BITS] || m_ready;
    assign s_ready = advance;

    // Stage valid bits
    assign valid_next = {valid_reg[DIV_BITS-1:0], s_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (advance) begin
            valid_reg <= valid_next;
        end
    end

    hsl_front #(
        .SAT_BITS (SATURATION_BITS),
        .DIV_BITS (DIV_BITS)
    ) u_front (
        .aclk    (aclk),
        .en      (advance),
        .red     (s_red),
        .green   (s_green),
        .blue    (s_blue),
        .opacity (s_opacity_in),
        .hue_rem (hue_rem[0]),
        .hue_low (hue_low[0]),
        .hue_den (hue_den[0]),
        .sat_rem (sat_rem[0]),
        .sat_low (sat_low[0]),
        .sat_den (sat_den[0]),
        .side    (side[0])
    );

    assign hue_quo[0] = '0;
    assign sat_quo[0] = '0;

    // One hue cell and one saturation cell per quotient bit
    for (genvar i = 0; i < DIV_BITS; i++) begin : g_cell
        hsl_div_cell #(
            .DEN_W (CHAN_W),
            .Q_W   (DIV_BITS)
        ) u_hue_cell (
            .aclk    (aclk),
            .en      (advance),
            .rem_in  (hue_rem[i]),
            .den_in  (hue_den[i]),
            .low_in  (hue_low[i]),
            .quo_in  (hue_quo[i]),
            .rem_out (hue_rem[i+1]),
            .den_out (hue_den[i+1]),
            .low_out (hue_low[i+1]),
            .quo_out (hue_quo[i+1])
        );

        hsl_div_cell #(
            .DEN_W (CHAN_W),
            .Q_W   (DIV_BITS)
        ) u_sat_cell (
            .aclk    (aclk),
            .en      (advance),
            .rem_in  (sat_rem[i]),
            .den_in  (sat_den[i]),
            .low_in  (sat_low[i]),
            .quo_in  (sat_quo[i]),
            .rem_out (sat_rem[i+1]),
            .den_out (sat_den[i+1]),
            .low_out (sat_low[i+1]),
            .quo_out (sat_quo[i+1])
        );

        // Carry lightness, opacity and the gray flag alongside
        always_ff @(posedge aclk) begin
            if (advance) begin
                side_reg[i+1] <= side[i];
            end
        end
        assign side[i+1] = side_reg[i+1];
    end

    // Result from the last cells; gray pixels force hue and saturation to zero
    assign m_valid       = valid_reg[DIV_BITS];
    assign m_hue         = side[DIV_BITS].gray ? '0 : hue_quo[DIV_BITS][HUE_W-1:0];
    assign m_saturation  = side[DIV_BITS].gray ? '0 : sat_quo[DIV_BITS][SATURATION_BITS-1:0];
    assign m_lightness   = side[DIV_BITS].lightness;
    assign m_opacity_out = side[DIV_BITS].opacity;

endmodule

// ===== sv/hsl_front.sv =====
// ----------------------------------------------------------------------------
// hsl_front: pixel preparation stage
// Finds max/min, lightness, saturation denominator and the two dividends,
// and registers them as the head of the divide chain.
// ----------------------------------------------------------------------------
module hsl_front import hsl_pkg::*; #(
    parameter int SAT_BITS = 16,
    parameter int DIV_BITS = 16
) (
    input  logic                aclk,
    input  logic                en,
    input  logic [CHAN_W-1:0]   red,
    input  logic [CHAN_W-1:0]   green,
    input  logic [CHAN_W-1:0]   blue,
    input  logic [CHAN_W-1:0]   opacity,
    output logic [CHAN_W-1:0]   hue_rem,
    output logic [DIV_BITS-1:0] hue_low,
    output logic [CHAN_W-1:0]   hue_den,
    output logic [CHAN_W-1:0]   sat_rem,
    output logic [DIV_BITS-1:0] sat_low,
    output logic [CHAN_W-1:0]   sat_den,
    output hsl_side_t           side
);

    localparam int DVD_W = DIV_BITS + CHAN_W;

    logic [CHAN_W-1:0]  hi, lo, d;
    logic [LIGHT_W-1:0] sum;
    logic [LIGHT_W-1:0] den_wide;
    logic [M_W-1:0]     base, m_val;
    logic [M_W-1:0]     add_term, sub_term;
    logic [N_W-1:0]     n_val;
    logic [DVD_W-1:0]   hue_dvd, sat_dvd;

    logic [CHAN_W-1:0]   hue_rem_reg, sat_rem_reg, d_reg, den_reg;
    logic [DIV_BITS-1:0] hue_low_reg, sat_low_reg;
    hsl_side_t           side_reg;

    // Extremes, spread and lightness
    always_comb begin
        hi  = (red > green) ? red : green;
        hi  = (hi > blue) ? hi : blue;
        lo  = (red < green) ? red : green;
        lo  = (lo < blue) ? lo : blue;
        d   = hi - lo;
        sum = LIGHT_W'(hi) + LIGHT_W'(lo);
        if (sum < LIGHT_W'(255)) begin
            den_wide = sum;
        end else begin
            den_wide = LIGHT_W'(510) - sum;
        end
    end

    // Sextant position M = offset*d + diff, wrapped into [0, 6d)
    always_comb begin
        if (red == hi) begin
            if (green >= blue) begin
                base = '0;
            end else begin
                base = M_W'(d) * M_W'(6);
            end
            add_term = M_W'(green);
            sub_term = M_W'(blue);
        end else if (green == hi) begin
            base     = M_W'(d) << 1;
            add_term = M_W'(blue);
            sub_term = M_W'(red);
        end else begin
            base     = M_W'(d) << 2;
            add_term = M_W'(red);
            sub_term = M_W'(green);
        end
        m_val = base + add_term - sub_term;
        n_val = (N_W'(m_val) << 6) - (N_W'(m_val) << 2);
        hue_dvd = DVD_W'(n_val);
        sat_dvd = (DVD_W'(d) << SAT_BITS) - DVD_W'(d);
    end

    // Register the head of the chain
    always_ff @(posedge aclk) begin
        if (en) begin
            hue_rem_reg <= hue_dvd[DVD_W-1:DIV_BITS];
            hue_low_reg <= hue_dvd[DIV_BITS-1:0];
            d_reg       <= d;
            sat_rem_reg <= sat_dvd[DVD_W-1:DIV_BITS];
            sat_low_reg <= sat_dvd[DIV_BITS-1:0];
            den_reg     <= den_wide[CHAN_W-1:0];
            side_reg    <= '{gray: (d == '0), lightness: sum, opacity: opacity};
        end
    end

    assign hue_rem = hue_rem_reg;
    assign hue_low = hue_low_reg;
    assign hue_den = d_reg;
    assign sat_rem = sat_rem_reg;
    assign sat_low = sat_low_reg;
    assign sat_den = den_reg;
    assign side    = side_reg;

endmodule

// ===== sv/hsl_div_cell.sv =====
// ----------------------------------------------------------------------------
// hsl_div_cell: one restoring-division cell
// Brings down one dividend bit, subtracts the divisor when it fits and
// shifts the resulting quotient bit in; hands everything to the next cell.
// ----------------------------------------------------------------------------
module hsl_div_cell import hsl_pkg::*; #(
    parameter int DEN_W = 8,
    parameter int Q_W   = 16
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [DEN_W-1:0] rem_in,
    input  logic [DEN_W-1:0] den_in,
    input  logic [Q_W-1:0]   low_in,
    input  logic [Q_W-1:0]   quo_in,
    output logic [DEN_W-1:0] rem_out,
    output logic [DEN_W-1:0] den_out,
    output logic [Q_W-1:0]   low_out,
    output logic [Q_W-1:0]   quo_out
);

    logic [DEN_W:0]   trial, diff;
    logic             fits;
    logic [DEN_W-1:0] rem_next;

    logic [DEN_W-1:0] rem_reg, den_reg;
    logic [Q_W-1:0]   low_reg, quo_reg;

    // Trial subtract of the divisor from the partial remainder
    always_comb begin
        trial    = {rem_in, low_in[Q_W-1]};
        diff     = trial - {1'b0, den_in};
        fits     = (trial >= {1'b0, den_in});
        rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end

    // Advance to the next cell
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg <= rem_next;
            den_reg <= den_in;
            low_reg <= {low_in[Q_W-2:0], 1'b0};
            quo_reg <= {quo_in[Q_W-2:0], fits};
        end
    end

    assign rem_out = rem_reg;
    assign den_out = den_reg;
    assign low_out = low_reg;
    assign quo_out = quo_reg;

endmodule
